// ===== src/vva_pkg.sv =====
`default_nettype none

package vva_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MODE_W     = 4;
  localparam int PROD_W     = 2 * DATA_W;
  // rounded dot product: sum of three full products, fraction dropped
  localparam int DOT_W      = 2 * DATA_W + 3 - FRAC_BITS;
  // widest value seen before saturation
  localparam int PRE_W      = DOT_W + 1;
  localparam int SHIFT_W    = $clog2(DATA_W);

  localparam int ARITH_LAT  = 7;
  localparam int NFRONT_LAT = 6;
  localparam int SQRT_STEPS = DATA_W;
  // unit vector components never exceed one, so the quotient needs one integer bit
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int DVD_W      = DATA_W + FRAC_BITS;
  localparam int DIV_LAT    = QUO_W + 1;
  localparam int NORM_LAT   = NFRONT_LAT + SQRT_STEPS + DIV_LAT;

  // neighbor lanes for the cross product
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  typedef enum logic [MODE_W-1:0] {
    OP_SCALE   = MODE_W'(0),
    OP_ADD     = MODE_W'(1),
    OP_SUB     = MODE_W'(2),
    OP_DOT     = MODE_W'(3),
    OP_CROSS   = MODE_W'(4),
    OP_NORM    = MODE_W'(5),
    OP_MUL     = MODE_W'(6),
    OP_REFLECT = MODE_W'(7),
    OP_LERP    = MODE_W'(8)
  } vva_op_e;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic [2:0][DATA_W-1:0] mag;
    logic [2:0]             neg;
    logic                   zl;
  } nrm_side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zl;
  } div_side_t;

  typedef struct packed {
    logic [2:0][DATA_W-1:0] res;
    logic [DATA_W-1:0]      sc;
    logic                   ov;
    logic                   nrm;
  } alu_res_t;

  function automatic logic sat_hit(input logic signed [PRE_W-1:0] v);
    logic [PRE_W-DATA_W:0] top;
    top = v[PRE_W-1:DATA_W-1];
    return !((&top) || !(|top));
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [PRE_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (sat_hit(v)) begin
      r = {v[PRE_W-1], {(DATA_W-1){~v[PRE_W-1]}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/vva_in_if.sv =====
`default_nettype none

interface vva_in_if;
  import vva_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  word_t             a_x;
  word_t             a_y;
  word_t             a_z;
  word_t             b_x;
  word_t             b_y;
  word_t             b_z;
  word_t             scalar_in;

  modport source (
    output valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
    input  ready
  );

  modport sink (
    input  valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/vva_out_if.sv =====
`default_nettype none

interface vva_out_if;
  import vva_pkg::*;

  logic  valid;
  logic  ready;
  word_t res_x;
  word_t res_y;
  word_t res_z;
  word_t res_scalar;
  logic  overflow;
  logic  zero_length;

  modport source (
    output valid, res_x, res_y, res_z, res_scalar, overflow, zero_length,
    input  ready
  );

  modport sink (
    input  valid, res_x, res_y, res_z, res_scalar, overflow, zero_length,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/vva_alu.sv =====
`default_nettype none

module vva_alu (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [vva_pkg::MODE_W-1:0]   mode_i,
  input  vva_pkg::word_t               a_i [3],
  input  vva_pkg::word_t               b_i [3],
  input  vva_pkg::word_t               s_i,
  output vva_pkg::alu_res_t            res_o
);
  import vva_pkg::*;

  localparam int OPA_W  = DATA_W + 1;
  localparam int PQ_W   = OPA_W + DATA_W;
  localparam int DIF_W  = PQ_W + 1;
  localparam int DSUM_W = PQ_W + 2;
  localparam logic signed [DIF_W-1:0]  HALF_DIF = DIF_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DSUM_W-1:0] HALF_DS  = DSUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] HALF_P   = PROD_W'(1) << (FRAC_BITS - 1);

  // stage 1: operand select
  logic signed [OPA_W-1:0] px_d [3];
  logic signed [OPA_W-1:0] as_d [3];
  word_t                   py_d [3];
  word_t                   qx_d [3];
  word_t                   qy_d [3];
  logic signed [OPA_W-1:0] px1_q [3];
  word_t                   py1_q [3];
  word_t                   qx1_q [3];
  word_t                   qy1_q [3];

  // carried along stages 1..6; b only along stages 1..4
  logic [MODE_W-1:0]       mode_q [6];
  word_t                   a_q    [6][3];
  logic signed [OPA_W-1:0] as_q   [6][3];
  word_t                   b_q    [4][3];

  // stage 2: products
  logic signed [PQ_W-1:0]   p2_q [3];
  logic signed [PROD_W-1:0] q2_q [3];

  // stage 3: rounding
  logic signed [DIF_W-1:0]  dif [3];
  logic signed [PRE_W-1:0]  w_d [3];
  logic signed [DSUM_W-1:0] dsum;
  logic signed [PRE_W-1:0]  w_q [4][3];
  logic signed [DOT_W-1:0]  dot3_q;

  // stage 4: dot clamp
  logic signed [PRE_W-1:0]  dotx;
  logic signed [PRE_W-1:0]  tw;
  word_t                    t4_q;
  logic [DATA_W-1:0]        sc_q  [3];
  logic                     ovd_q [3];
  logic                     ovd_d;

  // stages 5 and 6: reflect product and rounding
  logic signed [PROD_W-1:0] m5_q  [3];
  logic signed [PRE_W-1:0]  rm6_q [3];

  // stage 7: final select and saturation
  logic signed [PRE_W-1:0]  pre [3];
  alu_res_t                 res_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px_d[i] = OPA_W'(a_i[i]);
      py_d[i] = b_i[i];
      qx_d[i] = a_i[PRV[i]];
      qy_d[i] = b_i[NXT[i]];
      if (mode_i == OP_SUB) begin
        as_d[i] = OPA_W'(a_i[i]) - OPA_W'(b_i[i]);
      end else begin
        as_d[i] = OPA_W'(a_i[i]) + OPA_W'(b_i[i]);
      end
      unique case (mode_i)
        OP_SCALE: begin
          py_d[i] = s_i;
        end
        OP_CROSS: begin
          px_d[i] = OPA_W'(a_i[NXT[i]]);
          py_d[i] = b_i[PRV[i]];
        end
        OP_LERP: begin
          px_d[i] = OPA_W'(b_i[i]) - OPA_W'(a_i[i]);
          py_d[i] = s_i;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mode_q[1] == OP_CROSS) begin
        dif[i] = DIF_W'(p2_q[i]) - DIF_W'(q2_q[i]);
      end else begin
        dif[i] = DIF_W'(p2_q[i]);
      end
      w_d[i] = PRE_W'((dif[i] + HALF_DIF) >>> FRAC_BITS);
    end
    dsum = DSUM_W'(p2_q[0]) + DSUM_W'(p2_q[1]) + DSUM_W'(p2_q[2]) + HALF_DS;
  end

  always_comb begin
    dotx = PRE_W'(dot3_q);
    tw   = dotx <<< 1;
    if (mode_q[2] == OP_DOT) begin
      ovd_d = sat_hit(dotx);
    end else if (mode_q[2] == OP_REFLECT) begin
      ovd_d = sat_hit(tw);
    end else begin
      ovd_d = 1'b0;
    end
  end

  always_comb begin
    res_d     = '0;
    res_d.sc  = sc_q[2];
    res_d.nrm = (mode_q[5] == OP_NORM);
    res_d.ov  = ovd_q[2];
    for (int i = 0; i < 3; i++) begin
      unique case (mode_q[5])
        OP_SCALE, OP_CROSS, OP_MUL: pre[i] = w_q[3][i];
        OP_ADD, OP_SUB:             pre[i] = PRE_W'(as_q[5][i]);
        OP_REFLECT:                 pre[i] = PRE_W'(a_q[5][i]) - rm6_q[i];
        OP_LERP:                    pre[i] = PRE_W'(a_q[5][i]) + w_q[3][i];
        default:                    pre[i] = '0;
      endcase
      res_d.res[i] = sat32(pre[i]);
      res_d.ov     = res_d.ov | sat_hit(pre[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q[0] <= mode_i;
      for (int k = 1; k < 6; k++) begin
        mode_q[k] <= mode_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        px1_q[i]   <= px_d[i];
        py1_q[i]   <= py_d[i];
        qx1_q[i]   <= qx_d[i];
        qy1_q[i]   <= qy_d[i];
        a_q[0][i]  <= a_i[i];
        as_q[0][i] <= as_d[i];
        b_q[0][i]  <= b_i[i];
        for (int k = 1; k < 6; k++) begin
          a_q[k][i]  <= a_q[k-1][i];
          as_q[k][i] <= as_q[k-1][i];
        end
        for (int k = 1; k < 4; k++) begin
          b_q[k][i] <= b_q[k-1][i];
        end
        p2_q[i]   <= PQ_W'(px1_q[i]) * PQ_W'(py1_q[i]);
        q2_q[i]   <= PROD_W'(qx1_q[i]) * PROD_W'(qy1_q[i]);
        w_q[0][i] <= w_d[i];
        for (int k = 1; k < 4; k++) begin
          w_q[k][i] <= w_q[k-1][i];
        end
        m5_q[i]  <= PROD_W'(b_q[3][i]) * PROD_W'(t4_q);
        rm6_q[i] <= PRE_W'((m5_q[i] + HALF_P) >>> FRAC_BITS);
      end
      dot3_q   <= DOT_W'(dsum >>> FRAC_BITS);
      t4_q     <= sat32(tw);
      sc_q[0]  <= (mode_q[2] == OP_DOT) ? sat32(dotx) : '0;
      sc_q[1]  <= sc_q[0];
      sc_q[2]  <= sc_q[1];
      ovd_q[0] <= ovd_d;
      ovd_q[1] <= ovd_q[0];
      ovd_q[2] <= ovd_q[1];
      res_o    <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/vva_nfront.sv =====
`default_nettype none

module vva_nfront (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  vva_pkg::word_t              a_i [3],
  output vva_pkg::nrm_side_t          side_o,
  output logic [vva_pkg::PROD_W-1:0]  sum_o
);
  import vva_pkg::*;

  logic [DATA_W-1:0]  mag1_q [3];
  logic [DATA_W-1:0]  mag2_q [3];
  logic [DATA_W-1:0]  mag3_q [3];
  logic [DATA_W-1:0]  sm4_q  [3];
  logic [DATA_W-1:0]  sm5_q  [3];
  logic [PROD_W-1:0]  sq5_q  [3];
  logic [2:0]         neg_q  [5];
  logic [DATA_W-1:0]  max_d;
  logic [DATA_W-1:0]  max2_q;
  logic [SHIFT_W-1:0] pos;
  logic [SHIFT_W-1:0] k_d;
  logic [SHIFT_W-1:0] k3_q;
  logic               zl3_q;
  logic               zl4_q;
  logic               zl5_q;

  always_comb begin
    max_d = mag1_q[0];
    if (mag1_q[1] > max_d) begin
      max_d = mag1_q[1];
    end
    if (mag1_q[2] > max_d) begin
      max_d = mag1_q[2];
    end
  end

  // shift the largest magnitude up to just below the sign bit
  always_comb begin
    pos = '0;
    for (int j = 0; j < DATA_W; j++) begin
      if (max2_q[j]) begin
        pos = SHIFT_W'(j);
      end
    end
    if (max2_q[DATA_W-1]) begin
      k_d = '0;
    end else begin
      k_d = SHIFT_W'(DATA_W - 2) - pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i]   <= a_i[i][DATA_W-1] ? DATA_W'(-a_i[i]) : a_i[i];
        neg_q[0][i] <= a_i[i][DATA_W-1];
        mag2_q[i]   <= mag1_q[i];
        mag3_q[i]   <= mag2_q[i];
        sm4_q[i]    <= mag3_q[i] << k3_q;
        sm5_q[i]    <= sm4_q[i];
        sq5_q[i]    <= PROD_W'(sm4_q[i]) * PROD_W'(sm4_q[i]);
      end
      for (int k = 1; k < 5; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
      max2_q <= max_d;
      k3_q   <= k_d;
      zl3_q  <= (max2_q == '0);
      zl4_q  <= zl3_q;
      zl5_q  <= zl4_q;
      for (int i = 0; i < 3; i++) begin
        side_o.mag[i] <= sm5_q[i];
      end
      side_o.neg <= neg_q[4];
      side_o.zl  <= zl5_q;
      sum_o      <= sq5_q[0] + sq5_q[1] + sq5_q[2];
    end
  end

endmodule

`default_nettype wire

// ===== src/vva_isqrt.sv =====
`default_nettype none

module vva_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [vva_pkg::PROD_W-1:0]  n_i,
  input  vva_pkg::nrm_side_t          side_i,
  output logic [vva_pkg::DATA_W-1:0]  root_o,
  output vva_pkg::nrm_side_t          side_o
);
  import vva_pkg::*;

  localparam int CUR_W = DATA_W + 3;

  logic [DATA_W:0]   rem_in  [SQRT_STEPS];
  logic [DATA_W-1:0] root_in [SQRT_STEPS];
  logic [PROD_W-1:0] n_in    [SQRT_STEPS];
  logic [CUR_W-1:0]  cur     [SQRT_STEPS];
  logic [CUR_W-1:0]  trial   [SQRT_STEPS];
  logic [DATA_W:0]   rem_d   [SQRT_STEPS];
  logic [DATA_W-1:0] root_d  [SQRT_STEPS];

  logic [DATA_W:0]   rem_q  [SQRT_STEPS-1];
  logic [PROD_W-1:0] n_q    [SQRT_STEPS-1];
  logic [DATA_W-1:0] root_q [SQRT_STEPS];
  nrm_side_t         side_q [SQRT_STEPS];

  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    n_in[0]    = n_i;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      rem_in[j]  = rem_q[j-1];
      root_in[j] = root_q[j-1];
      n_in[j]    = n_q[j-1];
    end
    // one result bit per stage: bring down two radicand bits, try 4*root+1
    for (int j = 0; j < SQRT_STEPS; j++) begin
      cur[j]   = {rem_in[j], n_in[j][PROD_W-1 -: 2]};
      trial[j] = {1'b0, root_in[j], 2'b01};
      if (cur[j] >= trial[j]) begin
        rem_d[j]  = (DATA_W+1)'(cur[j] - trial[j]);
        root_d[j] = {root_in[j][DATA_W-2:0], 1'b1};
      end else begin
        rem_d[j]  = cur[j][DATA_W:0];
        root_d[j] = {root_in[j][DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        root_q[j] <= root_d[j];
        if (j > 0) begin
          side_q[j] <= side_q[j-1];
        end
        if (j < SQRT_STEPS - 1) begin
          rem_q[j] <= rem_d[j];
          n_q[j]   <= n_in[j] << 2;
        end
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];
  assign side_o = side_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ===== src/vva_div.sv =====
`default_nettype none

module vva_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [vva_pkg::DATA_W-1:0]  len_i,
  input  vva_pkg::nrm_side_t          side_i,
  output logic [vva_pkg::QUO_W-1:0]   quo_o [3],
  output vva_pkg::div_side_t          side_o
);
  import vva_pkg::*;

  logic [DVD_W-1:0]  dvd     [3];
  logic [DATA_W-1:0] rem_q   [QUO_W][3];
  logic [QUO_W-1:0]  lo_q    [QUO_W][3];
  logic [DATA_W-1:0] len_q   [QUO_W];
  logic [QUO_W-1:0]  quo_q   [QUO_W][3];
  div_side_t         side_q  [QUO_W+1];
  logic [QUO_W-1:0]  quo_in  [QUO_W][3];
  logic [DATA_W:0]   cur     [QUO_W][3];
  logic [DATA_W-1:0] rem_d   [QUO_W][3];
  logic [QUO_W-1:0]  quo_d   [QUO_W][3];

  // round to nearest: add half the divisor ahead of the division
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd[i] = (DVD_W'(side_i.mag[i]) << FRAC_BITS) + DVD_W'(len_i >> 1);
    end
  end

  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      for (int i = 0; i < 3; i++) begin
        quo_in[j][i] = (j == 0) ? '0 : quo_q[(j == 0) ? 0 : j - 1][i];
        cur[j][i]    = {rem_q[j][i], lo_q[j][i][QUO_W-1]};
        if (cur[j][i] >= {1'b0, len_q[j]}) begin
          rem_d[j][i] = DATA_W'(cur[j][i] - {1'b0, len_q[j]});
          quo_d[j][i] = {quo_in[j][i][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[j][i] = cur[j][i][DATA_W-1:0];
          quo_d[j][i] = {quo_in[j][i][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q[0]      <= len_i;
      side_q[0].neg <= side_i.neg;
      side_q[0].zl  <= side_i.zl;
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= DATA_W'(dvd[i][DVD_W-1:QUO_W]);
        lo_q[0][i]  <= dvd[i][QUO_W-1:0];
      end
      for (int j = 0; j < QUO_W; j++) begin
        side_q[j+1] <= side_q[j];
        for (int i = 0; i < 3; i++) begin
          quo_q[j][i] <= quo_d[j][i];
        end
        if (j < QUO_W - 1) begin
          len_q[j+1] <= len_q[j];
          for (int i = 0; i < 3; i++) begin
            rem_q[j+1][i] <= rem_d[j][i];
            lo_q[j+1][i]  <= lo_q[j][i] << 1;
          end
        end
      end
    end
  end

  assign quo_o  = quo_q[QUO_W-1];
  assign side_o = side_q[QUO_W];

endmodule

`default_nettype wire

// ===== src/vec3_vector_alu.sv =====
// Three-component vector ALU, signed Q16.16.
// Input channel in_i: an opcode (scale, add, sub, dot, cross, normalize,
// component multiply, reflect, lerp), vectors a and b and a scalar.
// Output channel res_o: one result item per input item, in order: the
// saturated vector, the dot product (dot opcode only), an overflow flag
// and a zero-length flag for normalizing a zero vector.
// Every opcode has the same depth from acceptance to res_o.valid. The
// depth is set by the normalize path: a 6-stage front end (magnitudes,
// max, shift, squares, sum), a 32-stage square root that settles one
// root bit per stage and an 18-stage divider (a load stage, then one
// quotient bit per stage). The other opcodes finish in 7 stages and
// ride a delay line to the output so results stay in order.
// Throughput: one item per cycle while res_o.ready is high.
// Stall: when the output register holds an item and res_o.ready is low,
// every stage freezes and in_i.ready drops; nothing is dropped or repeated.
// Reset: clears all valid bits; the pipeline comes up empty and ready.
`default_nettype none

module vec3_vector_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  vva_in_if.sink           in_i,
  vva_out_if.source        res_o
);
  import vva_pkg::*;

  localparam int DLY = NORM_LAT - ARITH_LAT;

  logic                 adv;
  logic [NORM_LAT-1:0]  vld_q;
  logic                 out_vld_q;

  word_t                a_v [3];
  word_t                b_v [3];

  alu_res_t             alu_res;
  alu_res_t             alu_q [DLY];
  alu_res_t             alu_fin;

  nrm_side_t            nf_side;
  logic [PROD_W-1:0]    nf_sum;
  nrm_side_t            sq_side;
  logic [DATA_W-1:0]    sq_root;
  logic [QUO_W-1:0]     quo [3];
  div_side_t            dv_side;

  logic [DATA_W-1:0]    res_d [3];
  logic [DATA_W-1:0]    sc_d;
  logic                 ov_d;
  logic                 zl_d;
  logic [DATA_W-1:0]    qext;
  word_t                res_q [3];
  word_t                sc_q;
  logic                 ov_q;
  logic                 zl_q;

  // advance whenever the output register is free or being drained
  assign adv        = ~out_vld_q | res_o.ready;
  assign in_i.ready = adv;

  assign a_v[0] = in_i.a_x;
  assign a_v[1] = in_i.a_y;
  assign a_v[2] = in_i.a_z;
  assign b_v[0] = in_i.b_x;
  assign b_v[1] = in_i.b_y;
  assign b_v[2] = in_i.b_z;

  vva_alu u_alu (
    .clk_i  (clk_i),
    .en_i   (adv),
    .mode_i (in_i.mode),
    .a_i    (a_v),
    .b_i    (b_v),
    .s_i    (in_i.scalar_in),
    .res_o  (alu_res)
  );

  vva_nfront u_nfront (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (a_v),
    .side_o (nf_side),
    .sum_o  (nf_sum)
  );

  vva_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .n_i    (nf_sum),
    .side_i (nf_side),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  vva_div u_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .len_i  (sq_root),
    .side_i (sq_side),
    .quo_o  (quo),
    .side_o (dv_side)
  );

  // hold short-path results until the normalize path catches up
  always_ff @(posedge clk_i) begin
    if (adv) begin
      alu_q[0] <= alu_res;
      for (int k = 1; k < DLY; k++) begin
        alu_q[k] <= alu_q[k-1];
      end
    end
  end

  assign alu_fin = alu_q[DLY-1];

  // pick the normalize quotient or the arithmetic result
  always_comb begin
    qext = '0;
    if (alu_fin.nrm) begin
      sc_d = '0;
      ov_d = 1'b0;
      zl_d = dv_side.zl;
      for (int i = 0; i < 3; i++) begin
        qext = DATA_W'(quo[i]);
        if (dv_side.zl) begin
          res_d[i] = '0;
        end else if (dv_side.neg[i]) begin
          res_d[i] = DATA_W'(0) - qext;
        end else begin
          res_d[i] = qext;
        end
      end
    end else begin
      sc_d = alu_fin.sc;
      ov_d = alu_fin.ov;
      zl_d = 1'b0;
      for (int i = 0; i < 3; i++) begin
        res_d[i] = alu_fin.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NORM_LAT-2:0], in_i.valid};
      out_vld_q <= vld_q[NORM_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        res_q[i] <= res_d[i];
      end
      sc_q <= sc_d;
      ov_q <= ov_d;
      zl_q <= zl_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.res_x       = res_q[0];
  assign res_o.res_y       = res_q[1];
  assign res_o.res_z       = res_q[2];
  assign res_o.res_scalar  = sc_q;
  assign res_o.overflow    = ov_q;
  assign res_o.zero_length = zl_q;

endmodule

`default_nettype wire
